// ----- rtl/bzcp_pkg.sv -----
// Shared types and constants for the Bezier control point block.
package bzcp_pkg;

    localparam int CoordW = 24;
    localparam int DiffW  = CoordW + 1;
    localparam int SqW    = 2 * DiffW - 1;
    localparam int LenW   = CoordW;
    localparam int QW     = 17;
    localparam int KW     = 9;
    localparam int QDEPTH = 4;
    localparam int QPTRW  = 2;

    // One segment job: four points and the two flags.
    typedef struct packed {
        logic signed [CoordW-1:0] p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;
        logic                     first;
        logic                     last;
    } t_job;

    // One finished segment.
    typedef struct packed {
        logic signed [CoordW-1:0] sx, sy, c1x, c1y, c2x, c2y, ex, ey;
        logic                     first;
        logic                     last;
    } t_res;

endpackage

// ----- rtl/bzcp_front.sv -----
// Front end: keeps the vertex window and turns each vertex into segment jobs.
module bzcp_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [bzcp_pkg::CoordW-1:0] i_x,
    input  logic signed [bzcp_pkg::CoordW-1:0] i_y,
    input  logic                               i_final_vertex,
    output logic                               o_job_valid,
    output bzcp_pkg::t_job                     o_job,
    input  logic                               i_job_ready
);

    logic signed [bzcp_pkg::CoordW-1:0] r_wx [3];
    logic signed [bzcp_pkg::CoordW-1:0] r_wy [3];
    logic [1:0] r_seen;
    logic       r_pend;
    bzcp_pkg::t_job r_pjob;
    logic       acc;
    logic       mid_job, fin_job;
    bzcp_pkg::t_job jm, jf;

    // Jobs that a vertex causes.
    always_comb begin
        mid_job = (r_seen >= 2'd2);
        fin_job = i_final_vertex && (r_seen != 2'd0);
        jm.p0x = (r_seen == 2'd3) ? r_wx[0] : r_wx[1];
        jm.p0y = (r_seen == 2'd3) ? r_wy[0] : r_wy[1];
        jm.p1x = r_wx[1]; jm.p1y = r_wy[1];
        jm.p2x = r_wx[2]; jm.p2y = r_wy[2];
        jm.p3x = i_x;     jm.p3y = i_y;
        jm.first = (r_seen == 2'd2);
        jm.last  = 1'b0;
        jf.p0x = (r_seen >= 2'd2) ? r_wx[1] : r_wx[2];
        jf.p0y = (r_seen >= 2'd2) ? r_wy[1] : r_wy[2];
        jf.p1x = r_wx[2]; jf.p1y = r_wy[2];
        jf.p2x = i_x;     jf.p2y = i_y;
        jf.p3x = i_x;     jf.p3y = i_y;
        jf.first = (r_seen == 2'd1);
        jf.last  = 1'b1;
    end

    // A vertex is taken only when its jobs can go out; a second job waits in r_pjob.
    assign o_stall     = r_pend || ((mid_job || fin_job) && !i_job_ready);
    assign acc         = i_valid && !o_stall;
    assign o_job_valid = r_pend || (i_valid && (mid_job || fin_job) && !r_pend);
    assign o_job       = r_pend ? r_pjob : (mid_job ? jm : jf);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 2'd0;
            r_pend <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_wx[i] <= '0;
                r_wy[i] <= '0;
            end
        end else begin
            if (r_pend && i_job_ready) begin
                r_pend <= 1'b0;
            end
            if (acc) begin
                r_wx[0] <= r_wx[1]; r_wx[1] <= r_wx[2]; r_wx[2] <= i_x;
                r_wy[0] <= r_wy[1]; r_wy[1] <= r_wy[2]; r_wy[2] <= i_y;
                r_seen  <= i_final_vertex ? 2'd0 :
                           ((r_seen == 2'd3) ? 2'd3 : r_seen + 2'd1);
                if (mid_job && fin_job) begin
                    r_pend <= 1'b1;
                    r_pjob <= jf;
                end
            end
        end
    end

endmodule

// ----- rtl/bzcp_queue.sv -----
// Short job queue between the front end and the math engine.
module bzcp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  bzcp_pkg::t_job i_data,
    output logic           o_ready,
    input  logic           i_rd,
    output logic           o_valid,
    output bzcp_pkg::t_job o_data
);

    bzcp_pkg::t_job r_mem [bzcp_pkg::QDEPTH];
    logic [bzcp_pkg::QPTRW-1:0] r_wp, r_rp;
    logic [bzcp_pkg::QPTRW:0]   r_cnt;
    logic wr, rd;

    assign o_ready = (r_cnt != (bzcp_pkg::QPTRW+1)'(bzcp_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign wr      = i_wr && o_ready;
    assign rd      = i_rd && o_valid;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (bzcp_pkg::QPTRW+1)'(wr) - (bzcp_pkg::QPTRW+1)'(rd);
        end
    end

endmodule

// ----- rtl/bzcp_engine.sv -----
// Back end: lengths by a shared square root, ratios by a shared divider, offsets.
module bzcp_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [bzcp_pkg::KW-1:0]        i_k,
    input  logic                           i_job_valid,
    input  bzcp_pkg::t_job                 i_job,
    output logic                           o_job_take,
    output logic                           o_valid,
    input  logic                           i_stall,
    output bzcp_pkg::t_res                 o_res
);

    localparam logic [3:0] S_IDLE = 4'd0, S_SQ = 4'd1, S_SQRT = 4'd2, S_DIV = 4'd3,
                           S_OFF = 4'd4, S_MUL = 4'd5, S_ADD = 4'd6, S_OUT = 4'd7;
    localparam int SW = bzcp_pkg::SqW;
    localparam int DW = bzcp_pkg::DiffW;
    localparam int CW = bzcp_pkg::CoordW;
    localparam int LW = bzcp_pkg::LenW;

    logic [3:0] r_st;
    bzcp_pkg::t_job r_job;
    logic [1:0] r_idx;       // which length, which ratio
    logic [SW-1:0] r_s, r_root;
    logic [5:0]    r_cnt;
    logic [LW-1:0] r_l [3];
    logic [LW+16:0] r_num;
    logic [LW:0]    r_den;
    logic [LW+1:0]  r_drem;
    logic [bzcp_pkg::QW-1:0] r_q [2];
    logic signed [DW-1:0] r_d;
    logic [DW-1:0]        r_md;
    logic [DW+bzcp_pkg::KW-1:0] r_mk;
    logic [DW+bzcp_pkg::KW+bzcp_pkg::QW-1:0] r_prod;
    logic signed [CW-1:0] r_c [4];
    logic [1:0] r_oi;
    logic [DW-1:0] ax_mag, ay_mag;
    logic signed [DW-1:0] dx, dy;
    logic [SW-1:0] sq_bit, trial;
    logic [LW+1:0] dsh;
    logic [bzcp_pkg::KW-1:0] kc;
    logic signed [CW-1:0] base;
    logic signed [DW-1:0] dsel;
    logic [DW+bzcp_pkg::KW+bzcp_pkg::QW-1:0] rnd;
    logic signed [DW+1:0] offs, sum;
    logic signed [CW-1:0] satv;
    logic [bzcp_pkg::QW-1:0] qsel;

    assign kc = (i_k > 9'd256) ? 9'd256 : i_k;
    assign o_job_take = (r_st == S_IDLE) && i_job_valid;
    assign o_valid = (r_st == S_OUT);

    // Difference for the current length.
    always_comb begin
        case (r_idx)
            2'd0: begin
                dx = DW'(r_job.p1x) - DW'(r_job.p0x); dy = DW'(r_job.p1y) - DW'(r_job.p0y);
            end
            2'd1: begin
                dx = DW'(r_job.p2x) - DW'(r_job.p1x); dy = DW'(r_job.p2y) - DW'(r_job.p1y);
            end
            default: begin
                dx = DW'(r_job.p3x) - DW'(r_job.p2x); dy = DW'(r_job.p3y) - DW'(r_job.p2y);
            end
        endcase
        ax_mag = dx[DW-1] ? DW'(-dx) : DW'(dx);
        ay_mag = dy[DW-1] ? DW'(-dy) : DW'(dy);
    end

    // The root bit under test is 4^(r_cnt-1); r_cnt runs from 24 down to 1.
    assign sq_bit = SW'(1) << {r_cnt[4:0] - 5'd1, 1'b0};
    assign trial  = r_root | sq_bit;
    assign dsh    = {r_drem[LW:0], r_num[LW+16]};

    // Offset operand selection: offset 0 c1x, 1 c1y, 2 c2x, 3 c2y.
    always_comb begin
        case (r_oi)
            2'd0: begin
                dsel = DW'(r_job.p2x) - DW'(r_job.p0x); base = r_job.p1x;
            end
            2'd1: begin
                dsel = DW'(r_job.p2y) - DW'(r_job.p0y); base = r_job.p1y;
            end
            2'd2: begin
                dsel = DW'(r_job.p3x) - DW'(r_job.p1x); base = r_job.p2x;
            end
            default: begin
                dsel = DW'(r_job.p3y) - DW'(r_job.p1y); base = r_job.p2y;
            end
        endcase
        qsel = r_oi[1] ? r_q[1] : r_q[0];
        rnd  = r_prod + (($bits(r_prod))'(1) << 24);
        offs = (DW+2)'(rnd >> 25);
        if (r_d < 0) offs = -offs;
        sum  = r_oi[1] ? ((DW+2)'(base) - offs) : ((DW+2)'(base) + offs);
        if (sum > (DW+2)'((1 <<< (CW-1)) - 1))   satv = {1'b0, {(CW-1){1'b1}}};
        else if (sum < -(DW+2)'(1 <<< (CW-1)))   satv = {1'b1, {(CW-1){1'b0}}};
        else                                     satv = CW'(sum);
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job; r_idx <= 2'd0; r_st <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_s <= SW'((ax_mag * ax_mag) >> 2) + SW'((ay_mag * ay_mag) >> 2);
                    r_root <= '0; r_cnt <= 6'd24;
                    r_st <= S_SQRT;
                end
                S_SQRT: begin
                    // One root bit per cycle, restoring method.
                    if (r_cnt == 6'd0) begin
                        r_l[r_idx] <= LW'(r_root);
                        if (r_idx == 2'd2) begin
                            r_idx <= 2'd0; r_st <= S_DIV;
                            r_num <= {1'b0, r_l[1], 16'd0}; r_drem <= '0; r_cnt <= 6'd41;
                            r_den <= (LW+1)'(r_l[0]) + (LW+1)'(r_l[1]);
                        end else begin
                            r_idx <= r_idx + 2'd1; r_st <= S_SQ;
                        end
                    end else begin
                        if (r_s >= trial) begin
                            r_s <= r_s - trial;
                            r_root <= (r_root >> 1) | sq_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_DIV: begin
                    // One quotient bit per cycle, restoring.
                    if (r_cnt == 6'd0) begin
                        if (r_den == '0) r_q[r_idx[0]] <= r_idx[0] ? '0 : 17'h10000;
                        else             r_q[r_idx[0]] <= bzcp_pkg::QW'(r_num);
                        if (r_idx == 2'd1) begin
                            r_oi <= 2'd0; r_st <= S_OFF;
                        end else begin
                            r_idx <= 2'd1; r_drem <= '0; r_cnt <= 6'd41;
                            r_num <= {1'b0, r_l[1], 16'd0};
                            r_den <= (LW+1)'(r_l[1]) + (LW+1)'(r_l[2]);
                        end
                    end else begin
                        if (dsh >= (LW+2)'(r_den)) begin
                            r_drem <= dsh - (LW+2)'(r_den);
                            r_num  <= {r_num[LW+15:0], 1'b1};
                        end else begin
                            r_drem <= dsh;
                            r_num  <= {r_num[LW+15:0], 1'b0};
                        end
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_OFF: begin
                    r_d  <= dsel;
                    r_md <= dsel[DW-1] ? DW'(-dsel) : DW'(dsel);
                    r_st <= S_MUL;
                    r_mk <= '0;
                end
                S_MUL: begin
                    // Magnitude times K, then times the ratio next cycle; a zero magnitude skips the first step.
                    if (r_mk == '0 && r_md != '0) begin
                        r_mk <= r_md * kc;
                        r_md <= '0;
                    end else begin
                        r_prod <= r_mk * qsel;
                        r_st <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_c[r_oi] <= satv;
                    r_oi <= r_oi + 2'd1;
                    r_st <= (r_oi == 2'd3) ? S_OUT : S_OFF;
                end
                S_OUT: begin
                    if (!i_stall) r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_res.sx = r_job.p1x; assign o_res.sy = r_job.p1y;
    assign o_res.c1x = r_c[0];   assign o_res.c1y = r_c[1];
    assign o_res.c2x = r_c[2];   assign o_res.c2y = r_c[3];
    assign o_res.ex = r_job.p2x; assign o_res.ey = r_job.p2y;
    assign o_res.first = r_job.first;
    assign o_res.last  = r_job.last;

endmodule

// ----- rtl/bezier_control_points.sv -----
// Top level: Bezier control points from a stream of polyline vertices.
// The engine works on one segment at a time: it takes the job, then runs three square roots,
// two divisions and four offset passes, and then shows the result.
// A vertex that closes two segments gives two results: the middle segment first, then the last.
// Synchronous active-low reset empties the window and queue and sets smoothing to 128.
module bezier_control_points (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [bzcp_pkg::CoordW-1:0] i_x,
    input  logic signed [bzcp_pkg::CoordW-1:0] i_y,
    input  logic                               i_final_vertex,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bzcp_pkg::KW-1:0]            i_cfg_data,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [bzcp_pkg::CoordW-1:0] o_start_x,
    output logic signed [bzcp_pkg::CoordW-1:0] o_start_y,
    output logic signed [bzcp_pkg::CoordW-1:0] o_ctrl1_x,
    output logic signed [bzcp_pkg::CoordW-1:0] o_ctrl1_y,
    output logic signed [bzcp_pkg::CoordW-1:0] o_ctrl2_x,
    output logic signed [bzcp_pkg::CoordW-1:0] o_ctrl2_y,
    output logic signed [bzcp_pkg::CoordW-1:0] o_end_x,
    output logic signed [bzcp_pkg::CoordW-1:0] o_end_y,
    output logic                               o_first_segment,
    output logic                               o_last_segment
);

    logic [bzcp_pkg::KW-1:0] r_k;
    logic fj_valid, q_ready, q_valid, take;
    bzcp_pkg::t_job fj, qj;
    bzcp_pkg::t_res res;

    // Smoothing register.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= 9'd128;
        end else if (i_cfg_valid) begin
            r_k <= i_cfg_data;
        end
    end

    bzcp_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_x, .i_y, .i_final_vertex,
        .o_job_valid(fj_valid), .o_job(fj), .i_job_ready(q_ready)
    );

    bzcp_queue u_queue (
        .i_clk, .i_rst_n, .i_wr(fj_valid), .i_data(fj), .o_ready(q_ready),
        .i_rd(take), .o_valid(q_valid), .o_data(qj)
    );

    bzcp_engine u_engine (
        .i_clk, .i_rst_n, .i_k(r_k), .i_job_valid(q_valid), .i_job(qj),
        .o_job_take(take), .o_valid, .i_stall, .o_res(res)
    );

    assign o_start_x = res.sx;  assign o_start_y = res.sy;
    assign o_ctrl1_x = res.c1x; assign o_ctrl1_y = res.c1y;
    assign o_ctrl2_x = res.c2x; assign o_ctrl2_y = res.c2y;
    assign o_end_x = res.ex;    assign o_end_y = res.ey;
    assign o_first_segment = res.first;
    assign o_last_segment  = res.last;

endmodule

// ----- rtl/bzcp_checker.sv -----
// Port-level checks for the Bezier control point block, bound to the top level.
module bzcp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_stall,
    input logic o_first_segment,
    input logic o_last_segment,
    input logic i_cfg_valid,
    input logic o_cfg_ready
);

    // A result under stall stays.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("result dropped under stall");

    // The segment flags of a stalled result do not change.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_first_segment) && $stable(o_last_segment))
        else $error("segment flags changed under stall");

    // Results are never shown in two consecutive cycles after a taken beat.
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |=> !o_valid) else $error("result beat repeated");

    // The configuration port is always ready.
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready) else $error("config beat refused");

    // No output right after reset.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("result after reset");

endmodule

bind bezier_control_points bzcp_checker u_bzcp_checker (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_first_segment, .o_last_segment,
    .i_cfg_valid, .o_cfg_ready
);
